[hdl/tmis_pkg.sv]
// Package for the tape machine instruction step block.
// Holds command and register codes and the stage control struct.
// No dependencies.
package tmis_pkg;

  localparam int CMD_W  = 4;
  localparam int CELL_W = 8;
  localparam int CFG_W  = 16;
  localparam int CFG_INDEX_W = 1;

  localparam logic [CMD_W-1:0] CMD_RIGHT = 4'd0;
  localparam logic [CMD_W-1:0] CMD_LEFT  = 4'd1;
  localparam logic [CMD_W-1:0] CMD_INC   = 4'd2;
  localparam logic [CMD_W-1:0] CMD_DEC   = 4'd3;
  localparam logic [CMD_W-1:0] CMD_OUT   = 4'd4;
  localparam logic [CMD_W-1:0] CMD_IN    = 4'd5;
  localparam logic [CMD_W-1:0] CMD_OPEN  = 4'd6;
  localparam logic [CMD_W-1:0] CMD_CLOSE = 4'd7;

  localparam logic [CFG_INDEX_W-1:0] REG_TAPE_LENGTH   = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_STRICT_BOUNDS = 1'd1;

  localparam logic [CFG_W-1:0] TAPE_LENGTH_RESET = 16'd32768;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [CELL_W-1:0] in_byte;
    logic              in_eof;
    logic              berr;
  } s1_ctrl_t;

endpackage

[hdl/tape_machine_instruction_step.sv]
// Top level of the tape machine instruction step block.
// Depends on tmis_pkg, tmis_tape_ram and tmis_exec.
//
// Usage: the host fetches instructions and matches brackets, and sends one
// request per instruction on the in_ channel (command, its program index, the
// matching bracket index and an input byte with its end-of-input flag). Each
// request yields exactly one result on the out_ channel: the next program
// index, the jump flag, an optional output byte and the bounds error flag.
// Both channels move a request when valid is high and stall is low.
// A result passes from the cell stage registers into the output register
// once its request is accepted and the cell stage can advance.
// One request per cycle is sustained while the receiver does not stall: the
// pointer is updated and the cell read is issued when the request is accepted,
// and the cell is modified and written back as the request leaves the cell
// stage, with the last written cell forwarded to the read. After reset the
// pointer is zero and the tape is cleared one cell per cycle, during which
// in_stall stays high; configuration writes are taken at any time. When the
// receiver stalls, the result waits in the output register and one more
// request can wait in the cell stage, after which in_stall rises.
module tape_machine_instruction_step #(
  parameter int TAPE_DEPTH         = 32768,
  parameter int PROGRAM_INDEX_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [tmis_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [tmis_pkg::CFG_W-1:0]        cfg_wdata,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [tmis_pkg::CMD_W-1:0]        in_command,
  input  logic [PROGRAM_INDEX_BITS-1:0]     in_instr_index,
  input  logic [PROGRAM_INDEX_BITS-1:0]     in_match_index,
  input  logic [tmis_pkg::CELL_W-1:0]       in_in_byte,
  input  logic                              in_in_eof,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [PROGRAM_INDEX_BITS:0]       out_next_index,
  output logic                              out_jump_taken,
  output logic                              out_out_valid,
  output logic [tmis_pkg::CELL_W-1:0]       out_out_byte,
  output logic                              out_bounds_error
);
  import tmis_pkg::*;

  localparam int PTR_W = $clog2(TAPE_DEPTH);
  localparam int LEN_W = (PTR_W + 1 > CFG_W) ? PTR_W + 1 : CFG_W;
  localparam logic [LEN_W-1:0] DEPTH_LEN = LEN_W'(TAPE_DEPTH);
  localparam logic [PTR_W-1:0] LAST_ADDR = PTR_W'(TAPE_DEPTH - 1);

  logic [CFG_W-1:0] tape_length_r;
  logic             strict_r;

  logic             clearing_r;
  logic [PTR_W-1:0] clr_addr_r;

  logic [PTR_W-1:0] ptr_r;
  logic [PTR_W-1:0] ptr_nxt;
  logic             berr_nxt;
  logic [LEN_W-1:0] tl_ext;
  logic [LEN_W-1:0] eff_len;
  logic [LEN_W-1:0] ptr_inc;

  logic                          s1_valid_r;
  s1_ctrl_t                      s1_ctrl_r;
  logic [PTR_W-1:0]              s1_addr_r;
  logic [PROGRAM_INDEX_BITS-1:0] s1_ip_r;
  logic [PROGRAM_INDEX_BITS-1:0] s1_match_r;

  logic              fwd_valid_r;
  logic [PTR_W-1:0]  fwd_addr_r;
  logic [CELL_W-1:0] fwd_data_r;

  logic                        accept;
  logic                        s1_adv;
  logic                        cell_we;
  logic [CELL_W-1:0]           cell_new;
  logic [CELL_W-1:0]           rd_data;
  logic [PROGRAM_INDEX_BITS:0] ex_next_index;
  logic                        ex_jump;
  logic                        ex_byte_valid;
  logic [CELL_W-1:0]           ex_byte;
  logic                        ex_berr;
  logic                        mem_we;
  logic [PTR_W-1:0]            mem_waddr;
  logic [CELL_W-1:0]           mem_wdata;

  logic                        out_valid_r;
  logic [PROGRAM_INDEX_BITS:0] out_next_index_r;
  logic                        out_jump_r;
  logic                        out_byte_valid_r;
  logic [CELL_W-1:0]           out_byte_r;
  logic                        out_berr_r;

  assign s1_adv   = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = clearing_r || (s1_valid_r && !s1_adv);
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tape_length_r <= TAPE_LENGTH_RESET;
      strict_r      <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_TAPE_LENGTH:   tape_length_r <= cfg_wdata;
        REG_STRICT_BOUNDS: strict_r      <= cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (clearing_r) begin
      clr_addr_r <= clr_addr_r + 1'b1;
      if (clr_addr_r == LAST_ADDR) begin
        clearing_r <= 1'b0;
      end
    end
  end

  assign tl_ext  = LEN_W'(tape_length_r);
  assign eff_len = (tl_ext == '0) ? LEN_W'(1) :
                   (tl_ext > DEPTH_LEN) ? DEPTH_LEN : tl_ext;
  assign ptr_inc = LEN_W'(ptr_r) + 1'b1;

  always_comb begin
    ptr_nxt  = ptr_r;
    berr_nxt = 1'b0;
    unique case (in_command)
      CMD_RIGHT: begin
        if (ptr_inc >= eff_len) begin
          if (strict_r) begin
            berr_nxt = 1'b1;
          end else begin
            ptr_nxt = '0;
          end
        end else begin
          ptr_nxt = ptr_inc[PTR_W-1:0];
        end
      end
      CMD_LEFT: begin
        if (ptr_r == '0) begin
          if (strict_r) begin
            berr_nxt = 1'b1;
          end else begin
            ptr_nxt = PTR_W'(eff_len - 1'b1);
          end
        end else begin
          ptr_nxt = ptr_r - 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r      <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        ptr_r <= ptr_nxt;
      end
      if (accept) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_ctrl_r.cmd     <= in_command;
      s1_ctrl_r.in_byte <= in_in_byte;
      s1_ctrl_r.in_eof  <= in_in_eof;
      s1_ctrl_r.berr    <= berr_nxt;
      s1_addr_r         <= ptr_r;
      s1_ip_r           <= in_instr_index;
      s1_match_r        <= in_match_index;
    end
  end

  assign mem_we    = clearing_r || (s1_adv && cell_we);
  assign mem_waddr = clearing_r ? clr_addr_r : s1_addr_r;
  assign mem_wdata = clearing_r ? '0 : cell_new;

  tmis_tape_ram #(
    .DEPTH  (TAPE_DEPTH),
    .ADDR_W (PTR_W)
  ) u_ram (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_waddr),
    .wr_data (mem_wdata),
    .rd_en   (accept),
    .rd_addr (ptr_r),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_valid_r <= 1'b0;
    end else if (s1_adv && cell_we) begin
      fwd_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && cell_we) begin
      fwd_addr_r <= s1_addr_r;
      fwd_data_r <= cell_new;
    end
  end

  tmis_exec #(
    .PROGRAM_INDEX_BITS (PROGRAM_INDEX_BITS)
  ) u_exec (
    .ctrl         (s1_ctrl_r),
    .instr_index  (s1_ip_r),
    .match_index  (s1_match_r),
    .rd_data      (rd_data),
    .fwd_hit      (fwd_valid_r && (fwd_addr_r == s1_addr_r)),
    .fwd_data     (fwd_data_r),
    .cell_we      (cell_we),
    .cell_new     (cell_new),
    .next_index   (ex_next_index),
    .jump_taken   (ex_jump),
    .byte_valid   (ex_byte_valid),
    .byte_out     (ex_byte),
    .bounds_error (ex_berr)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_next_index_r <= ex_next_index;
      out_jump_r       <= ex_jump;
      out_byte_valid_r <= ex_byte_valid;
      out_byte_r       <= ex_byte;
      out_berr_r       <= ex_berr;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_next_index   = out_next_index_r;
  assign out_jump_taken   = out_jump_r;
  assign out_out_valid    = out_byte_valid_r;
  assign out_out_byte     = out_byte_r;
  assign out_bounds_error = out_berr_r;

endmodule

[hdl/tmis_tape_ram.sv]
// Tape cell memory: one synchronous write port and one registered read port.
// Uses tmis_pkg for the cell width.
module tmis_tape_ram #(
  parameter int DEPTH  = 32768,
  parameter int ADDR_W = 15
) (
  input  logic                       clk,
  input  logic                       wr_en,
  input  logic [ADDR_W-1:0]          wr_addr,
  input  logic [tmis_pkg::CELL_W-1:0] wr_data,
  input  logic                       rd_en,
  input  logic [ADDR_W-1:0]          rd_addr,
  output logic [tmis_pkg::CELL_W-1:0] rd_data
);
  import tmis_pkg::*;

  logic [CELL_W-1:0] mem [DEPTH];
  logic [CELL_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[hdl/tmis_exec.sv]
// Cell stage of the instruction step: selects the forwarded or stored cell,
// computes the new cell value and the result fields. Uses tmis_pkg.
module tmis_exec #(
  parameter int PROGRAM_INDEX_BITS = 16
) (
  input  tmis_pkg::s1_ctrl_t               ctrl,
  input  logic [PROGRAM_INDEX_BITS-1:0]    instr_index,
  input  logic [PROGRAM_INDEX_BITS-1:0]    match_index,
  input  logic [tmis_pkg::CELL_W-1:0]      rd_data,
  input  logic                             fwd_hit,
  input  logic [tmis_pkg::CELL_W-1:0]      fwd_data,
  output logic                             cell_we,
  output logic [tmis_pkg::CELL_W-1:0]      cell_new,
  output logic [PROGRAM_INDEX_BITS:0]      next_index,
  output logic                             jump_taken,
  output logic                             byte_valid,
  output logic [tmis_pkg::CELL_W-1:0]      byte_out,
  output logic                             bounds_error
);
  import tmis_pkg::*;

  logic [CELL_W-1:0]           cell_val;
  logic                        cell_zero;
  logic [PROGRAM_INDEX_BITS:0] seq_index;
  logic [PROGRAM_INDEX_BITS:0] jump_index;

  assign cell_val   = fwd_hit ? fwd_data : rd_data;
  assign cell_zero  = (cell_val == '0);
  assign seq_index  = {1'b0, instr_index} + 1'b1;
  assign jump_index = {1'b0, match_index} + 1'b1;
  assign bounds_error = ctrl.berr;

  always_comb begin
    cell_we    = 1'b0;
    cell_new   = cell_val;
    next_index = seq_index;
    jump_taken = 1'b0;
    byte_valid = 1'b0;
    byte_out   = '0;
    unique case (ctrl.cmd)
      CMD_RIGHT, CMD_LEFT: begin
        if (ctrl.berr) begin
          next_index = {1'b0, instr_index};
        end
      end
      CMD_INC: begin
        cell_we  = 1'b1;
        cell_new = cell_val + 1'b1;
      end
      CMD_DEC: begin
        cell_we  = 1'b1;
        cell_new = cell_val - 1'b1;
      end
      CMD_OUT: begin
        byte_valid = 1'b1;
        byte_out   = cell_val;
      end
      CMD_IN: begin
        cell_we  = 1'b1;
        cell_new = ctrl.in_eof ? '0 : ctrl.in_byte;
      end
      CMD_OPEN: begin
        if (cell_zero) begin
          jump_taken = 1'b1;
          next_index = jump_index;
        end
      end
      CMD_CLOSE: begin
        if (!cell_zero) begin
          jump_taken = 1'b1;
          next_index = jump_index;
        end
      end
      default: begin
      end
    endcase
  end

endmodule
